// File: hw/rtl/scrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scrb_pkg
// Shared types and constants of the stream chunk reorder buffer.
// ----------------------------------------------------------------------------
package scrb_pkg;

	localparam int unsigned NumContextsDef = 16;
	localparam int unsigned WindowDef      = 16;
	// slot offset width, covers the largest window
	localparam int unsigned OfsW           = 6;

	localparam logic [2:0] KIND_DELIVER  = 3'd0;
	localparam logic [2:0] KIND_COMPLETE = 3'd1;
	localparam logic [2:0] KIND_BEYOND   = 3'd2;
	localparam logic [2:0] KIND_NOCTX    = 3'd3;
	localparam logic [2:0] KIND_STALE    = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ERASE,
		ST_DECIDE,
		ST_SLOTWR,
		ST_DRAIN_RD,
		ST_DRAIN_CHK,
		ST_FINISH,
		ST_CLEAR
	} state_t;

	// per-context record held in the context memory
	typedef struct packed {
		logic            end_seen;
		logic [16:0]     next_seq;
		logic [16:0]     seen_count;
		logic [OfsW-1:0] next_ofs;
	} ctx_rec_t;

endpackage : scrb_pkg
`default_nettype wire

// File: hw/rtl/scrb_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scrb_slot_mem
// Slot store: one present bit and payload handle per window slot.
// Synchronous single-port memory with registered read data.
// ----------------------------------------------------------------------------
module scrb_slot_mem
	import scrb_pkg::*;
#(
	parameter int unsigned DEPTH = NumContextsDef * WindowDef,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] addr,
	input  wire logic          we,
	input  wire logic [16:0]   wdata,
	output logic [16:0]        rdata
);

	logic [16:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule : scrb_slot_mem
`default_nettype wire

// File: hw/rtl/stream_chunk_reorder_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stream_chunk_reorder_buffer
// Per-stream reorder of chunks with in-order delivery and completion.
// Lookup scans every context in turn; a drop (stale, beyond window, no free
// context) is then strobed. A stored chunk first clears the window when it opens
// a context, is written to its slot, then in-order chunks are drained and the
// context is written back or closed. Erase frees every context of the peer and
// clears its window. One at a time. Reset: clearing pass over the slot memory,
// busy high meanwhile. Results are strobed; the receiver cannot stall.
// ----------------------------------------------------------------------------
module stream_chunk_reorder_buffer
	import scrb_pkg::*;
#(
	parameter int unsigned NUM_CONTEXTS = NumContextsDef,
	parameter int unsigned WINDOW       = WindowDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [15:0] peer,
	input  wire logic [31:0] stream_id,
	input  wire logic [15:0] seq,
	input  wire logic        end_flag,
	input  wire logic [15:0] chunk_tag,
	output logic             strobe,
	output logic [2:0]       kind,
	output logic [15:0]      out_peer,
	output logic [31:0]      out_stream,
	output logic [16:0]      index,
	output logic [15:0]      out_tag,
	output logic             last
);

	localparam int unsigned CW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int unsigned WW    = $clog2(WINDOW);
	localparam int unsigned NSLOT = NUM_CONTEXTS * WINDOW;
	localparam int unsigned SW    = $clog2(NSLOT);

	state_t state_q, state_d;

	// context memories
	logic [NUM_CONTEXTS-1:0] valid_q;
	logic [15:0]  cpeer_mem   [NUM_CONTEXTS];
	logic [31:0]  cstream_mem [NUM_CONTEXTS];
	ctx_rec_t     crec_mem    [NUM_CONTEXTS];
	logic [15:0]  cpeer_rd;
	logic [31:0]  cstream_rd;
	ctx_rec_t     crec_rd;
	logic [CW-1:0] crd_addr;

	// latched request
	logic        endf_q;
	logic [15:0] peer_q, seq_q, tag_q;
	logic [31:0] stream_q;

	logic [CW:0]   scan_q;
	logic [CW-1:0] rd_idx_q;
	logic          rd_v_q;
	logic          found_q, freef_q;
	logic [CW-1:0] found_idx_q, free_idx_q;
	ctx_rec_t      rec_q;
	logic [WW:0]   wcnt_q;
	logic [SW:0]   clr_q;

	// delivered beat held until the next slot decides its last flag
	logic          hold_v_q;
	logic [16:0]   hold_idx_q;
	logic [15:0]   hold_tag_q;

	// slot memory
	logic [SW-1:0] s_addr;
	logic          s_we;
	logic [16:0]   s_wdata, s_rdata;

	scrb_slot_mem #(.DEPTH(NSLOT), .AW(SW)) u_slot (
		.clk(clk), .addr(s_addr), .we(s_we), .wdata(s_wdata), .rdata(s_rdata)
	);

	logic [16:0] seq17, hi_lim;
	logic [16:0] sdiff;
	logic [OfsW:0] ofs_sum, seq_ofs;
	logic        c_we;
	ctx_rec_t    c_wrec;
	logic        c_new;
	logic        o_stb, o_last;
	logic [2:0]  o_kind;
	logic [16:0] o_idx;
	logic [15:0] o_tag;
	logic [SW:0] s_full;

	assign seq17  = {1'b0, seq_q};
	assign hi_lim = rec_q.next_seq + 17'(WINDOW);
	assign crd_addr = scan_q[CW-1:0];
	assign busy   = (state_q != ST_IDLE);

	// slot offset of seq: it lies within the window above next_seq
	assign sdiff   = seq17 - rec_q.next_seq;
	assign ofs_sum = {1'b0, rec_q.next_ofs} + {1'b0, sdiff[OfsW-1:0]};
	assign seq_ofs = (ofs_sum >= (OfsW+1)'(WINDOW)) ? ofs_sum - (OfsW+1)'(WINDOW) : ofs_sum;

	always_ff @(posedge clk) begin
		cpeer_rd   <= cpeer_mem[crd_addr];
		cstream_rd <= cstream_mem[crd_addr];
		crec_rd    <= crec_mem[crd_addr];
		if (c_new) begin
			cpeer_mem[found_idx_q]   <= peer_q;
			cstream_mem[found_idx_q] <= stream_q;
		end
		if (c_we) begin
			crec_mem[found_idx_q] <= c_wrec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			valid_q  <= '0;
			clr_q    <= '0;
			scan_q   <= '0;
			rd_v_q   <= 1'b0;
			strobe   <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= o_stb;
			rd_v_q  <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					scan_q <= '0;
					if (start) begin
						found_q <= 1'b0;
						freef_q <= 1'b0;
						wcnt_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_q < (CW+1)'(NUM_CONTEXTS)) begin
						scan_q   <= scan_q + 1'b1;
						rd_idx_q <= crd_addr;
						rd_v_q   <= 1'b1;
					end
					if (rd_v_q) begin
						if (valid_q[rd_idx_q]) begin
							if (!found_q && cpeer_rd == peer_q && cstream_rd == stream_q) begin
								found_q     <= 1'b1;
								found_idx_q <= rd_idx_q;
								rec_q       <= crec_rd;
							end
						end else if (!freef_q) begin
							freef_q    <= 1'b1;
							free_idx_q <= rd_idx_q;
						end
					end
				end
				ST_ERASE: begin
					// wcnt_q counts slot clears of the context under erase
					if (wcnt_q != '0) begin
						wcnt_q <= wcnt_q + 1'b1;
						if (wcnt_q == (WW+1)'(WINDOW)) begin
							wcnt_q <= '0;
							valid_q[found_idx_q] <= 1'b0;
						end
					end else begin
						if (scan_q < (CW+1)'(NUM_CONTEXTS)) begin
							scan_q   <= scan_q + 1'b1;
							rd_idx_q <= crd_addr;
							rd_v_q   <= 1'b1;
						end
						if (rd_v_q && valid_q[rd_idx_q] && cpeer_rd == peer_q) begin
							found_idx_q <= rd_idx_q;
							wcnt_q      <= (WW+1)'(1);
							// hold scan: re-read after clear
							scan_q      <= {1'b0, rd_idx_q} + 1'b1;
							rd_v_q      <= 1'b0;
						end
					end
				end
				ST_DECIDE: begin
					hold_v_q <= 1'b0;
					if (!found_q) begin
						rec_q <= '0;
					end
					if (!found_q && freef_q) begin
						found_idx_q <= free_idx_q;
						wcnt_q      <= '0;
					end
				end
				ST_SLOTWR: begin
					if (!found_q) begin
						wcnt_q <= wcnt_q + 1'b1;
						if (wcnt_q == (WW+1)'(WINDOW - 1)) begin
							found_q <= 1'b1;
							valid_q[found_idx_q] <= 1'b1;
						end
					end else begin
						if (endf_q) rec_q.end_seen <= 1'b1;
						if (seq17 + 1'b1 > rec_q.seen_count) begin
							rec_q.seen_count <= seq17 + 1'b1;
						end
					end
				end
				ST_DRAIN_CHK: begin
					if (s_rdata[16]) begin
						rec_q.next_seq <= rec_q.next_seq + 1'b1;
						rec_q.next_ofs <= (rec_q.next_ofs == OfsW'(WINDOW - 1)) ?
							'0 : rec_q.next_ofs + 1'b1;
						hold_v_q   <= 1'b1;
						hold_idx_q <= rec_q.next_seq;
						hold_tag_q <= s_rdata[15:0];
					end
				end
				ST_FINISH: begin
					if (rec_q.end_seen && rec_q.next_seq >= rec_q.seen_count) begin
						valid_q[found_idx_q] <= 1'b0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_IDLE && start) begin
				peer_q   <= peer;
				stream_q <= stream_id;
				seq_q    <= seq;
				endf_q   <= end_flag;
				tag_q    <= chunk_tag;
			end
		end
	end

	// a freed context needs no slot clear: allocation clears its window

	always_ff @(posedge clk) begin
		kind       <= o_kind;
		out_peer   <= peer_q;
		out_stream <= stream_q;
		index      <= o_idx;
		out_tag    <= o_tag;
		last       <= o_last;
	end

	always_comb begin
		state_d = state_q;
		s_addr  = '0;
		s_we    = 1'b0;
		s_wdata = '0;
		c_we    = 1'b0;
		c_new   = 1'b0;
		c_wrec  = rec_q;
		o_stb   = 1'b0;
		o_last  = 1'b0;
		o_kind  = KIND_DELIVER;
		o_idx   = '0;
		o_tag   = '0;
		s_full  = clr_q;
		case (state_q)
			ST_CLEAR: begin
				s_addr = s_full[SW-1:0];
				s_we   = 1'b1;
				if (clr_q == (SW+1)'(NSLOT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = func ? ST_ERASE : ST_SCAN;
			end
			ST_SCAN: begin
				if (!rd_v_q && scan_q == (CW+1)'(NUM_CONTEXTS)) state_d = ST_DECIDE;
			end
			ST_ERASE: begin
				if (wcnt_q != '0) begin
					s_addr = SW'({found_idx_q, wcnt_q[WW-1:0] - 1'b1});
					if (WINDOW != (1 << WW)) begin
						s_addr = SW'(found_idx_q * WINDOW + (wcnt_q - 1'b1));
					end
					s_we = 1'b1;
				end else if (!rd_v_q && scan_q == (CW+1)'(NUM_CONTEXTS)) begin
					state_d = ST_IDLE;
				end
			end
			ST_DECIDE: begin
				o_idx = seq17;
				if (found_q && seq17 < rec_q.next_seq) begin
					o_stb = 1'b1; o_last = 1'b1; o_kind = KIND_STALE;
					state_d = ST_IDLE;
				end else if (seq17 >= (found_q ? hi_lim : 17'(WINDOW))) begin
					o_stb = 1'b1; o_last = 1'b1; o_kind = KIND_BEYOND;
					state_d = ST_IDLE;
				end else if (!found_q && !freef_q) begin
					o_stb = 1'b1; o_last = 1'b1; o_kind = KIND_NOCTX;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SLOTWR;
				end
			end
			ST_SLOTWR: begin
				if (!found_q) begin
					// fresh context: clear its window first
					c_new  = 1'b1;
					s_addr = SW'(found_idx_q * WINDOW + wcnt_q);
					s_we   = 1'b1;
				end else begin
					s_addr  = SW'(found_idx_q * WINDOW + seq_ofs);
					s_we    = 1'b1;
					s_wdata = {1'b1, tag_q};
					state_d = ST_DRAIN_RD;
				end
			end
			ST_DRAIN_RD: begin
				s_addr = SW'(found_idx_q * WINDOW + rec_q.next_ofs);
				if (rec_q.next_seq < rec_q.seen_count) begin
					state_d = ST_DRAIN_CHK;
				end else begin
					// drain over: last unless completion follows
					o_stb   = hold_v_q;
					o_kind  = KIND_DELIVER;
					o_idx   = hold_idx_q;
					o_tag   = hold_tag_q;
					o_last  = !rec_q.end_seen;
					state_d = ST_FINISH;
				end
			end
			ST_DRAIN_CHK: begin
				s_addr = SW'(found_idx_q * WINDOW + rec_q.next_ofs);
				o_stb  = hold_v_q;
				o_kind = KIND_DELIVER;
				o_idx  = hold_idx_q;
				o_tag  = hold_tag_q;
				if (s_rdata[16]) begin
					s_we    = 1'b1;
					o_last  = 1'b0;
					state_d = ST_DRAIN_RD;
				end else begin
					o_last  = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				c_we = 1'b1;
				if (rec_q.end_seen && rec_q.next_seq >= rec_q.seen_count) begin
					o_stb   = 1'b1;
					o_last  = 1'b1;
					o_kind  = KIND_COMPLETE;
					o_idx   = rec_q.next_seq;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule : stream_chunk_reorder_buffer
`default_nettype wire
